/* design/pcapng_frame_encapsulator_unit_macros.svh */
// Assertion helpers for the top-level design file.
`ifndef PCAPNG_FRAME_ENCAPSULATOR_UNIT_MACROS_SVH
`define PCAPNG_FRAME_ENCAPSULATOR_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define PFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/pfe_pkg.sv */
// -----------------------------------------------------------------------------
// pfe_pkg
// Types, codes and constant tables of the pcapng frame encapsulator.
// -----------------------------------------------------------------------------
package pfe_pkg;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_HEADER = 2'd1;
	localparam logic [1:0] OP_BYTE   = 2'd2;

	localparam logic [2:0] BUS_CAN     = 3'd0;
	localparam logic [2:0] BUS_CANFD   = 3'd1;
	localparam logic [2:0] BUS_LIN     = 3'd2;
	localparam logic [2:0] BUS_FLEXRAY = 3'd3;
	localparam logic [2:0] BUS_ETH     = 3'd4;

	localparam logic [8:0] LINK_CAN     = 9'd227;
	localparam logic [8:0] LINK_LIN     = 9'd254;
	localparam logic [8:0] LINK_FLEXRAY = 9'd259;
	localparam logic [8:0] LINK_ETH     = 9'd1;

	// command kinds between front and back
	localparam logic [1:0] CMD_FILE = 2'd0;
	localparam logic [1:0] CMD_HEAD = 2'd1;
	localparam logic [1:0] CMD_DATA = 2'd2;

	localparam logic [31:0] SHB_TYPE   = 32'h0A0D0D0A;
	localparam logic [31:0] SHB_LEN    = 32'd32;
	localparam logic [31:0] BOM_MAGIC  = 32'h1A2B3C4D;
	localparam logic [31:0] SHB_VER    = 32'h00000001;
	localparam logic [31:0] NO_LIMIT   = 32'hFFFFFFFF;
	localparam logic [31:0] IDB_TYPE   = 32'h00000001;
	localparam logic [31:0] IDB_LEN    = 32'd24;
	localparam logic [31:0] EPB_TYPE   = 32'h00000006;
	localparam logic [31:0] CAN_EFF    = 32'h80000000;
	localparam logic [28:0] CAN_SFF_MAX = 29'h7FF;

	localparam logic [11:0] EPB_OVERHEAD   = 12'd32;
	localparam logic [5:0]  FILE_HDR_BYTES = 6'd56;
	localparam logic [5:0]  EPB_HEAD_BYTES = 6'd28;
	localparam logic [5:0]  TRAILER_BYTES  = 6'd4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0]       kind;
		logic             tail;   // block closes after this command
		logic [1:0]       pad;
		logic [11:0]      blen;
		logic [11:0]      cap;
		logic [3:0]       hlen;
		logic [7:0][7:0]  ph;     // pseudo-header, ph[0] goes out first
		logic [63:0]      ts;
		logic [7:0]       data;
		logic [8:0]       dlt;
	} pfe_cmd_t;

	function automatic logic [8:0] link_type(input logic [2:0] bus);
		logic [8:0] lt;
		case (bus)
			BUS_LIN:     lt = LINK_LIN;
			BUS_FLEXRAY: lt = LINK_FLEXRAY;
			BUS_ETH:     lt = LINK_ETH;
			default:     lt = LINK_CAN;
		endcase
		return lt;
	endfunction

	// section header block followed by interface description block, word by word
	function automatic logic [31:0] file_hdr_word(input logic [3:0] w, input logic [8:0] dlt);
		logic [31:0] v;
		case (w)
			4'd0:    v = SHB_TYPE;
			4'd1:    v = SHB_LEN;
			4'd2:    v = BOM_MAGIC;
			4'd3:    v = SHB_VER;
			4'd4:    v = NO_LIMIT;
			4'd5:    v = NO_LIMIT;
			4'd6:    v = 32'd0;
			4'd7:    v = SHB_LEN;
			4'd8:    v = IDB_TYPE;
			4'd9:    v = IDB_LEN;
			4'd10:   v = {23'd0, dlt};
			4'd11:   v = NO_LIMIT;
			4'd12:   v = 32'd0;
			4'd13:   v = IDB_LEN;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// little-endian byte select
	function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
		logic [7:0] b;
		unique case (sel)
			2'd0: b = w[7:0];
			2'd1: b = w[15:8];
			2'd2: b = w[23:16];
			2'd3: b = w[31:24];
		endcase
		return b;
	endfunction

endpackage

/* design/pfe_in_if.sv */
// -----------------------------------------------------------------------------
// pfe_in_if
// Input channel: operation items with frame header fields or a payload byte.
// -----------------------------------------------------------------------------
interface pfe_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [2:0]  frame_bus;
	logic [28:0] frame_id;
	logic [10:0] payload_length;
	logic        flexray_channel;
	logic [5:0]  cycle_count;
	logic [63:0] timestamp_ns;
	logic [7:0]  payload_byte;

	modport source (
		output valid, operation, frame_bus, frame_id, payload_length,
		       flexray_channel, cycle_count, timestamp_ns, payload_byte,
		input  ready
	);
	modport sink (
		input  valid, operation, frame_bus, frame_id, payload_length,
		       flexray_channel, cycle_count, timestamp_ns, payload_byte,
		output ready
	);
endinterface

/* design/pfe_out_if.sv */
// -----------------------------------------------------------------------------
// pfe_out_if
// Output channel: pcapng stream bytes with an end-of-item mark.
// -----------------------------------------------------------------------------
interface pfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
endinterface

/* design/pfe_front.sv */
// -----------------------------------------------------------------------------
// pfe_front
// Accepts input items, tracks the open packet block and issues byte commands.
// -----------------------------------------------------------------------------
module pfe_front import pfe_pkg::*; #(
	parameter int MAX_FRAME_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	pfe_in_if.sink     frame_in,
	input  logic       q_full,
	output logic       q_push,
	output pfe_cmd_t   q_cmd
);

	localparam logic [11:0] LEN_LIMIT =
		(MAX_FRAME_BYTES > 2047) ? 12'd2047 : 12'(MAX_FRAME_BYTES);

	logic [2:0]  bus_kind_q;
	logic [10:0] owed_q;
	logic [1:0]  pad_q;
	logic [11:0] blen_q;

	logic [10:0] owed_d;
	logic [1:0]  pad_d;
	logic [11:0] blen_d;
	logic        accept;

	logic [10:0]     len_c;
	logic [7:0][7:0] ph;
	logic [3:0]      hlen;
	logic [31:0]     can_word;
	logic [11:0]     cap;
	logic [1:0]      pad_new;
	logic [11:0]     blen_new;

	assign frame_in.ready = !q_full;
	assign accept = frame_in.valid && !q_full;

	// pseudo-header and block sizes for a header item
	always_comb begin
		len_c = ({1'b0, frame_in.payload_length} > LEN_LIMIT) ? LEN_LIMIT[10:0]
			: frame_in.payload_length;
		ph = '0;
		can_word = {3'd0, frame_in.frame_id};
		if (frame_in.frame_id > CAN_SFF_MAX) begin
			can_word = can_word | CAN_EFF;
		end
		case (frame_in.frame_bus)
			BUS_LIN: begin
				hlen  = 4'd5;
				ph[0] = 8'd1;
				ph[1] = {4'b0100, len_c[3:0]};
				ph[2] = frame_in.frame_id[7:0];
			end
			BUS_ETH: begin
				hlen = 4'd0;
			end
			BUS_FLEXRAY: begin
				hlen  = 4'd7;
				ph[0] = {frame_in.flexray_channel, 7'd1};
				ph[2] = {frame_in.frame_id[6:0], 1'b0};
				ph[3] = {4'd0, frame_in.frame_id[10:7]};
				ph[4] = {1'b0, len_c[7:1]};
				ph[6] = {2'd0, frame_in.cycle_count};
			end
			default: begin
				hlen  = 4'd8;
				ph[0] = can_word[31:24];
				ph[1] = can_word[23:16];
				ph[2] = can_word[15:8];
				ph[3] = can_word[7:0];
				ph[4] = len_c[7:0];
				ph[7] = (len_c == 11'd8) ? 8'd9 : 8'd0;
			end
		endcase
		cap      = {8'd0, hlen} + {1'b0, len_c};
		pad_new  = 2'd0 - cap[1:0];
		blen_new = EPB_OVERHEAD + cap + {10'd0, pad_new};
	end

	always_comb begin
		q_push = 1'b0;
		q_cmd  = '0;
		owed_d = owed_q;
		pad_d  = pad_q;
		blen_d = blen_q;
		if (accept) begin
			unique case (frame_in.operation)
				OP_START: begin
					q_push     = 1'b1;
					q_cmd.kind = CMD_FILE;
					q_cmd.dlt  = link_type(bus_kind_q);
					owed_d     = '0;
					pad_d      = '0;
					blen_d     = '0;
				end
				OP_HEADER: begin
					// header is dropped while payload is still owed
					if (owed_q == '0) begin
						q_push     = 1'b1;
						q_cmd.kind = CMD_HEAD;
						q_cmd.tail = (len_c == '0);
						q_cmd.pad  = pad_new;
						q_cmd.blen = blen_new;
						q_cmd.cap  = cap;
						q_cmd.hlen = hlen;
						q_cmd.ph   = ph;
						q_cmd.ts   = frame_in.timestamp_ns;
						owed_d     = len_c;
						pad_d      = (len_c == '0) ? 2'd0 : pad_new;
						blen_d     = (len_c == '0) ? 12'd0 : blen_new;
					end
				end
				OP_BYTE: begin
					if (owed_q != '0) begin
						q_push     = 1'b1;
						q_cmd.kind = CMD_DATA;
						q_cmd.tail = (owed_q == 11'd1);
						q_cmd.pad  = pad_q;
						q_cmd.blen = blen_q;
						q_cmd.data = frame_in.payload_byte;
						owed_d     = owed_q - 11'd1;
						if (owed_q == 11'd1) begin
							pad_d  = '0;
							blen_d = '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_kind_q <= '0;
			owed_q     <= '0;
			pad_q      <= '0;
			blen_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				bus_kind_q <= cfg_wr_data;
			end
			owed_q <= owed_d;
			pad_q  <= pad_d;
			blen_q <= blen_d;
		end
	end

endmodule

/* design/pfe_queue.sv */
// -----------------------------------------------------------------------------
// pfe_queue
// Short command queue between front and back.
// -----------------------------------------------------------------------------
module pfe_queue import pfe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pfe_cmd_t push_cmd,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output pfe_cmd_t head
);

	pfe_cmd_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW:0]    wr_ptr_q;
	logic [QUEUE_AW:0]    rd_ptr_q;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[QUEUE_AW-1:0] == rd_ptr_q[QUEUE_AW-1:0])
		&& (wr_ptr_q[QUEUE_AW] != rd_ptr_q[QUEUE_AW]);
	assign head  = mem_q[rd_ptr_q[QUEUE_AW-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q[QUEUE_AW-1:0]] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

/* design/pfe_back.sv */
// -----------------------------------------------------------------------------
// pfe_back
// Walks each command byte by byte into the registered output stage.
// -----------------------------------------------------------------------------
module pfe_back import pfe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_empty,
	input  pfe_cmd_t q_head,
	output logic     q_pop,
	pfe_out_if.source stream_out
);

	pfe_cmd_t   cur_q;
	logic       busy_q;
	logic [5:0] idx_q;
	logic [5:0] nbody_q;
	logic [5:0] end_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic       advance;
	logic       done;
	logic       load;
	logic [5:0] head_nbody;
	logic [5:0] head_end;
	logic [5:0] off;
	logic [5:0] tidx;
	logic [5:0] ph_off;
	logic [31:0] head_word;
	logic [7:0] byte_d;

	assign advance = busy_q && (!out_valid_q || stream_out.ready);
	assign done    = (idx_q == end_q);
	assign load    = !q_empty && (!busy_q || (advance && done));
	assign q_pop   = load;

	// byte count of the next command
	always_comb begin
		unique case (q_head.kind)
			CMD_FILE: head_nbody = FILE_HDR_BYTES;
			CMD_HEAD: head_nbody = EPB_HEAD_BYTES + {2'd0, q_head.hlen};
			default:  head_nbody = 6'd1;
		endcase
		head_end = head_nbody - 6'd1;
		if (q_head.tail) begin
			head_end = head_end + {4'd0, q_head.pad} + TRAILER_BYTES;
		end
	end

	always_comb begin
		off    = idx_q - nbody_q;
		tidx   = off - {4'd0, cur_q.pad};
		ph_off = idx_q - EPB_HEAD_BYTES;
		case (idx_q[4:2])
			3'd0:    head_word = EPB_TYPE;
			3'd1:    head_word = {20'd0, cur_q.blen};
			3'd3:    head_word = cur_q.ts[63:32];
			3'd4:    head_word = cur_q.ts[31:0];
			3'd5:    head_word = {20'd0, cur_q.cap};
			3'd6:    head_word = {20'd0, cur_q.cap};
			default: head_word = 32'd0;
		endcase
		if (cur_q.kind == CMD_FILE) begin
			byte_d = word_byte(file_hdr_word(idx_q[5:2], cur_q.dlt), idx_q[1:0]);
		end else if (idx_q < nbody_q) begin
			if (cur_q.kind == CMD_DATA) begin
				byte_d = cur_q.data;
			end else if (idx_q < EPB_HEAD_BYTES) begin
				byte_d = word_byte(head_word, idx_q[1:0]);
			end else begin
				byte_d = cur_q.ph[ph_off[2:0]];
			end
		end else if (off < {4'd0, cur_q.pad}) begin
			byte_d = 8'd0;
		end else begin
			// trailing copy of the block length
			byte_d = word_byte({20'd0, cur_q.blen}, tidx[1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q   <= q_head;
			nbody_q <= head_nbody;
			end_q   <= head_end;
		end
		if (advance) begin
			out_byte_q <= byte_d;
			out_last_q <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance) begin
				if (done) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 6'd1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (stream_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stream_out.valid    = out_valid_q;
	assign stream_out.out_byte = out_byte_q;
	assign stream_out.last     = out_last_q;

endmodule

/* design/pcapng_frame_encapsulator_unit.sv */
// -----------------------------------------------------------------------------
// pcapng_frame_encapsulator_unit
// Wraps bus frames as a little-endian pcapng byte stream.
//
//   channel      dir  handshake      payload
//   frame_in     in   valid/ready    operation, frame fields, payload_byte
//   stream_out   out  valid/ready    out_byte, last
//   cfg          in   cfg_wr_en      cfg_wr_data (capture bus kind)
//
// The output sequencer sends one byte per cycle while stream_out is ready; a
// start item is 56 bytes, a frame header 28 plus its pseudo-header bytes, and
// the block trailer adds padding plus 4. The front takes an item per
// cycle while the four-entry command queue has room. Reset clears block
// tracking, the queue and the output stage; the bus kind register resets to CAN.
// -----------------------------------------------------------------------------
`include "pcapng_frame_encapsulator_unit_macros.svh"

module pcapng_frame_encapsulator_unit import pfe_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	pfe_in_if.sink     frame_in,
	pfe_out_if.source  stream_out
);

	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_empty;
	pfe_cmd_t push_cmd;
	pfe_cmd_t head_cmd;

	pfe_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.frame_in   (frame_in),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd)
	);

	pfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (head_cmd)
	);

	pfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head_cmd),
		.q_pop     (q_pop),
		.stream_out(stream_out)
	);

	`PFE_ASSERT(a_no_overflow, !(q_push && q_full), "command pushed into full queue")
	`PFE_ASSERT(a_no_underflow, !(q_pop && q_empty), "command popped from empty queue")
	`PFE_ASSERT_NEXT(a_burst_cont, stream_out.valid && stream_out.ready && !stream_out.last, stream_out.valid, "gap inside an item's byte burst")

endmodule
